### rtl/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared constants for the 12-bit LZW compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

   // first learned code; codes below stand for single bytes
   localparam int unsigned FIRST_CODE = 256;

   // multiplier of the multiplicative slot hash
   localparam logic [15:0] HASH_MULT = 16'd40503;

   // width of an emitted code
   localparam int unsigned OUT_W = 12;

endpackage

### rtl/lzwc_ram.sv
// ----------------------------------------------------------------------------
// lzwc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lzwc_hash.sv
// ----------------------------------------------------------------------------
// lzwc_hash
// Registered multiplicative hash: slot = (key * HASH_MULT) mod HASH_SLOTS.
// HASH_SLOTS is a power of two, so only the low key bits matter.
// ----------------------------------------------------------------------------
module lzwc_hash #(
   parameter int unsigned HASH_W = 13
) (
   input  logic              clock,
   input  logic [HASH_W-1:0] key_lo,
   output logic [HASH_W-1:0] slot
);

   logic [HASH_W+15:0] prod;
   logic [HASH_W-1:0]  slot_ff;

   // product of the low key bits and the hash constant
   assign prod = (HASH_W+16)'(key_lo) * (HASH_W+16)'(lzwc_pkg::HASH_MULT);

   always_ff @(posedge clock) begin
      slot_ff <= prod[HASH_W-1:0];
   end

   assign slot = slot_ff;

endmodule

### rtl/lzw_compressor_12bit_top.sv
// ----------------------------------------------------------------------------
// lzw_compressor_12bit_top
// LZW compressor, one byte per transaction, 12-bit codes out.
// ----------------------------------------------------------------------------
//   channel | direction | handshake       | payload
//   req     | in        | valid / stall   | data_byte, end_of_stream
//   rsp     | out       | valid / stall   | code, final_code
//   csr     | in        | valid / ready   | grow_enable
//
// The first byte of a stream only passes through the finish step. Any other
// byte is hashed, then probes the dictionary RAM (one read port, registered
// read) in read and check steps, with a learn step and an emit step on a miss;
// a final code adds its own emit step. A stalled rsp holds the emit step. A
// clearing pass over all HASH_SLOTS entries runs after reset, after every
// end-of-stream byte and after each dictionary reset; req is stalled meanwhile. HASH_SLOTS must be a power of two.
// ----------------------------------------------------------------------------
module lzw_compressor_12bit_top #(
   parameter int unsigned DICT_CODES = 4096,
   parameter int unsigned HASH_SLOTS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_code,
   output logic        rsp_final_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_grow_enable
);

   localparam int unsigned PW      = $clog2(DICT_CODES);
   localparam int unsigned NW      = PW + 1;
   localparam int unsigned HW      = $clog2(HASH_SLOTS);
   localparam int unsigned KEY_W   = PW + 8;
   localparam int unsigned ENTRY_W = 1 + KEY_W + PW;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_START, S_READ, S_CHECK,
      S_MISS, S_EMIT1, S_FINISH, S_EMIT2
   } state_type;

   state_type         state_ff;
   logic              grow_ff;
   logic [PW-1:0]     prefix_ff;
   logic              pvalid_ff;
   logic [NW-1:0]     nfc_ff;
   logic [7:0]        byte_ff;
   logic              last_ff;
   logic [HW-1:0]     probe_ff;
   logic [HW-1:0]     cnt_ff;
   logic              empty_ok_ff;
   logic              clear_pend_ff;
   logic              rsp_valid_ff;
   logic [11:0]       rsp_code_ff;
   logic              rsp_final_ff;

   logic [KEY_W-1:0]  key;
   logic [HW-1:0]     hash_slot;
   logic [ENTRY_W-1:0] rd_data;
   logic              ent_valid;
   logic [KEY_W-1:0]  ent_key;
   logic [PW-1:0]     ent_code;
   logic              wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic              rsp_free;
   logic              emit_now;
   logic              can_learn;

   assign key       = {prefix_ff, byte_ff};
   assign ent_valid = rd_data[ENTRY_W-1];
   assign ent_key   = rd_data[ENTRY_W-2 -: KEY_W];
   assign ent_code  = rd_data[PW-1:0];
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_now  = rsp_free && (state_ff == S_EMIT1 || state_ff == S_EMIT2);
   assign can_learn = grow_ff && (nfc_ff < NW'(DICT_CODES)) && empty_ok_ff;

   // RAM write: zeros while clearing, a new entry on a learned miss
   always_comb begin
      wr_en   = 1'b0;
      wr_data = '0;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
      end else if (state_ff == S_MISS && can_learn) begin
         wr_en   = 1'b1;
         wr_data = {1'b1, key, nfc_ff[PW-1:0]};
      end
   end

   lzwc_hash #(.HASH_W(HW)) u_hash (
      .clock  (clock),
      .key_lo (key[HW-1:0]),
      .slot   (hash_slot)
   );

   lzwc_ram #(.WIDTH(ENTRY_W), .DEPTH(HASH_SLOTS)) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (probe_ff),
      .wr_data (wr_data),
      .rd_addr (probe_ff),
      .rd_data (rd_data)
   );

   // sequencer, dictionary state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         grow_ff       <= 1'b1;
         prefix_ff     <= '0;
         pvalid_ff     <= 1'b0;
         nfc_ff        <= NW'(lzwc_pkg::FIRST_CODE);
         probe_ff      <= '0;
         cnt_ff        <= '0;
         empty_ok_ff   <= 1'b0;
         clear_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            grow_ff <= csr_grow_enable;
         end
         // drop valid once taken, unless a new code goes out this cycle
         if (rsp_valid_ff && !rsp_stall && !emit_now) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               probe_ff <= probe_ff + 1'b1;
               if (probe_ff == HW'(HASH_SLOTS - 1)) begin
                  nfc_ff        <= NW'(lzwc_pkg::FIRST_CODE);
                  clear_pend_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  byte_ff <= req_data_byte;
                  last_ff <= req_end_of_stream;
                  if (pvalid_ff) begin
                     state_ff <= S_HASH;
                  end else begin
                     prefix_ff <= PW'(req_data_byte);
                     pvalid_ff <= 1'b1;
                     state_ff  <= S_FINISH;
                  end
               end
            end
            S_HASH: begin
               state_ff <= S_START;
            end
            S_START: begin
               probe_ff <= hash_slot;
               cnt_ff   <= '0;
               state_ff <= S_READ;
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (!ent_valid) begin
                  empty_ok_ff <= 1'b1;
                  state_ff    <= S_MISS;
               end else if (ent_key == key) begin
                  prefix_ff <= ent_code;
                  state_ff  <= S_FINISH;
               end else if (cnt_ff == HW'(HASH_SLOTS - 1)) begin
                  empty_ok_ff <= 1'b0;
                  state_ff    <= S_MISS;
               end else begin
                  probe_ff <= probe_ff + 1'b1;
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_MISS: begin
               if (can_learn) begin
                  nfc_ff <= nfc_ff + 1'b1;
               end
               state_ff <= S_EMIT1;
            end
            S_EMIT1: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_code_ff  <= 12'(prefix_ff);
                  rsp_final_ff <= 1'b0;
                  prefix_ff    <= PW'(byte_ff);
                  if (grow_ff && nfc_ff >= NW'(DICT_CODES)) begin
                     clear_pend_ff <= 1'b1;
                  end
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               probe_ff <= '0;
               if (last_ff) begin
                  state_ff <= S_EMIT2;
               end else if (clear_pend_ff) begin
                  state_ff <= S_CLEAR;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_EMIT2: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_code_ff  <= 12'(prefix_ff);
                  rsp_final_ff <= 1'b1;
                  prefix_ff    <= '0;
                  pvalid_ff    <= 1'b0;
                  state_ff     <= S_CLEAR;
               end
            end
            default: begin
               state_ff <= S_CLEAR;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code       = rsp_code_ff;
   assign rsp_final_code = rsp_final_ff;

   // next free code never passes the dictionary size
   a_nfc_range: assert property (@(posedge clock) disable iff (reset)
      nfc_ff <= NW'(DICT_CODES))
      else $error("next free code out of range");

   // a live prefix is always a code already handed out
   a_prefix_known: assert property (@(posedge clock) disable iff (reset)
      (pvalid_ff && state_ff == S_IDLE) |-> (NW'(prefix_ff) < nfc_ff))
      else $error("prefix code not yet assigned");

   // the final code ends the stream and starts a clearing pass
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT2 && rsp_free) |=>
         (state_ff == S_CLEAR && !pvalid_ff && rsp_final_ff && rsp_valid_ff))
      else $error("final code did not restart the stream");

endmodule

### tb/lzw_compressor_12bit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzw_compressor_12bit_top_tb
// Self-checking bench for the 12-bit LZW compressor. Byte streams go in on
// req and emitted codes are checked against a local dictionary model with the
// same hash and linear probing. Growth is switched on and off between phases.
// ----------------------------------------------------------------------------
module lzw_compressor_12bit_top_tb;

   localparam int unsigned DICT_CODES = 4096;
   localparam int unsigned HASH_SLOTS = 8192;
   localparam int unsigned IDLE_LIMIT = 60000;
   localparam int unsigned SETTLE_CYC = 400;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic [11:0] code;
      logic        final_code;
   } code_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_code;
   logic        rsp_final_code;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_grow_enable = 1'b0;

   lzw_compressor_12bit_top #(
      .DICT_CODES(DICT_CODES),
      .HASH_SLOTS(HASH_SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_code(rsp_code),
      .rsp_final_code(rsp_final_code),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_grow_enable(csr_grow_enable)
   );

   always #5 clock = ~clock;

   // dictionary model state
   bit          dict_used [HASH_SLOTS];
   logic [23:0] dict_key  [HASH_SLOTS];
   logic [12:0] dict_code [HASH_SLOTS];
   logic [12:0] free_code;
   logic [11:0] prefix;
   bit          have_prefix;
   bit          grow_en;

   byte_item_type byte_q[$];
   code_item_type code_q[$];

   int unsigned bytes_taken;
   int unsigned codes_checked;
   int unsigned streams_done;
   int unsigned error_count;
   int unsigned idle_cycles;
   int unsigned req_gap;
   int unsigned rsp_gap;
   bit          calm;
   bit          req_taken;

   function automatic void clear_dict();
      for (int i = 0; i < HASH_SLOTS; i++) dict_used[i] = 1'b0;
      free_code = 13'(lzwc_pkg::FIRST_CODE);
   endfunction

   // one byte through the dictionary; expected codes go to code_q
   function automatic void compress_byte(input logic [7:0] b, input logic last);
      logic [23:0]   key;
      logic [63:0]   prod;
      int unsigned   slot;
      int unsigned   empty;
      bit            hit;
      logic [12:0]   hit_code;
      code_item_type c;
      if (!have_prefix) begin
         prefix      = 12'(b);
         have_prefix = 1'b1;
      end else begin
         key   = {prefix, b};
         prod  = 64'(key) * 64'd40503;
         slot  = int'(prod % HASH_SLOTS);
         empty = HASH_SLOTS;
         hit   = 1'b0;
         for (int n = 0; n < HASH_SLOTS; n++) begin
            if (!dict_used[slot]) begin
               empty = slot;
               break;
            end
            if (dict_key[slot] == key) begin
               hit      = 1'b1;
               hit_code = dict_code[slot];
               break;
            end
            slot = (slot + 1) % HASH_SLOTS;
         end
         if (hit) begin
            prefix = hit_code[11:0];
         end else begin
            if (grow_en && free_code < DICT_CODES && empty < HASH_SLOTS) begin
               dict_used[empty] = 1'b1;
               dict_key[empty]  = key;
               dict_code[empty] = free_code;
               free_code++;
            end
            c.code       = prefix;
            c.final_code = 1'b0;
            code_q.push_back(c);
            if (grow_en && free_code >= DICT_CODES) clear_dict();
            prefix = 12'(b);
         end
      end
      if (last) begin
         c.code       = prefix;
         c.final_code = 1'b1;
         code_q.push_back(c);
         prefix      = '0;
         have_prefix = 1'b0;
         clear_dict();
      end
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random stream; narrow alphabets build long dictionary chains
   task automatic add_stream(input int unsigned len);
      logic [7:0]    base;
      bit            narrow;
      byte_item_type it;
      base   = $urandom_range(0, 255);
      narrow = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
         it.data_byte = narrow ? (base ^ 8'($urandom_range(0, 3)))
                               : 8'($urandom_range(0, 255));
         it.last      = (i == len - 1);
         byte_q.push_back(it);
      end
   endtask

   task automatic add_byte(input logic [7:0] b, input logic last);
      byte_item_type it;
      it.data_byte = b;
      it.last      = last;
      byte_q.push_back(it);
   endtask

   // drain everything, let the block settle, then write the register
   task automatic write_grow(input logic v);
      while (byte_q.size() != 0 || req_valid || code_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_grow_enable <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      byte_item_type it;
      if (!reset && !(req_valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (byte_q.size() != 0) begin
            it = byte_q.pop_front();
            req_data_byte     <= it.data_byte;
            req_end_of_stream <= it.last;
            req_valid         <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_gap = pick_gap();
         rsp_stall <= (rsp_gap > 0);
      end
   end

   // monitor: predict on each accepted byte, check each accepted code
   always @(posedge clock) begin
      code_item_type want;
      bit            moved;
      moved     = 1'b0;
      req_taken = req_valid && !req_stall && !reset;
      if (req_taken) begin
         compress_byte(req_data_byte, req_end_of_stream);
         bytes_taken++;
         if (req_end_of_stream) streams_done++;
         moved = 1'b1;
      end
      if (!reset && csr_valid && csr_ready) begin
         grow_en = csr_grow_enable;
         moved   = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         moved = 1'b1;
         if (code_q.size() == 0) begin
            $display("%0t: unexpected code: expected none, got code=%0d final=%0b",
                     $time, rsp_code, rsp_final_code);
            error_count++;
         end else begin
            want = code_q.pop_front();
            if (rsp_code !== want.code) begin
               $display("%0t: code mismatch: expected %0d, got %0d",
                        $time, want.code, rsp_code);
               error_count++;
            end
            if (rsp_final_code !== want.final_code) begin
               $display("%0t: final_code mismatch: expected %0b, got %0b",
                        $time, want.final_code, rsp_final_code);
               error_count++;
            end
            codes_checked++;
         end
      end
      // watchdog
      if (reset || moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // sequencer
   initial begin
      int unsigned rand_items;
      clear_dict();
      prefix      = '0;
      have_prefix = 1'b0;
      grow_en     = 1'b1;
      calm        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: lone last byte, field extremes, repeats that grow chains
      write_grow(1'b1);
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      for (int i = 0; i < 6; i++) add_byte(8'hFF, i == 5);
      for (int i = 0; i < 9; i++) add_byte(i[0] ? 8'h55 : 8'hAA, i == 8);
      // growth off: single-byte codes only
      write_grow(1'b0);
      for (int i = 0; i < 6; i++) add_byte(8'h41, i == 5);

      // random phases, switching growth between them
      rand_items = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_grow(ph == 1 || ph == 3 ? 1'b0 : 1'b1);
         calm = (ph == 2);
         while (rand_items < (ph + 1) * 190) begin
            int unsigned len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                              : $urandom_range(10, 90);
            add_stream(len);
            rand_items += len;
         end
      end
      calm = 1'b0;

      while (byte_q.size() != 0 || req_valid || code_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      if (code_q.size() != 0) error_count += code_q.size();
      $display("Covered %0d bytes in %0d streams, %0d codes checked,",
               bytes_taken, streams_done, codes_checked);
      $display("with growth on and off and random gaps on both channels.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
